// ===== rtl/core/mpc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Multiset permutation check package
// Shared control types for the count lanes, the merge stage and the top level.
// ----------------------------------------------------------------------------
package mpc_pkg;

  // Write controls for one count lane.
  typedef struct packed {
    logic inc_en;
    logic clr_en;
  } mpc_wr_ctrl_t;

  // What the merge stage reports for the pair it is processing.
  typedef struct packed {
    logic res_valid;
    logic same_multiset;
    logic count_overflow;
    logic sweep_req;
  } mpc_merge_t;

endpackage

// ===== rtl/core/mpc_pair_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pair channel
// Valid/ready channel that carries one element of each sequence per transaction.
// ----------------------------------------------------------------------------
interface mpc_pair_if #(
  parameter int VALUE_BITS = 10
) ();
  logic                  valid;
  logic                  ready;
  logic [VALUE_BITS-1:0] value_a;
  logic [VALUE_BITS-1:0] value_b;
  logic                  last_pair;

  modport source (output valid, output value_a, output value_b, output last_pair,
                  input ready);
  modport sink (input valid, input value_a, input value_b, input last_pair,
                output ready);
endinterface

// ===== rtl/core/mpc_result_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel that carries the verdict for one finished set.
// ----------------------------------------------------------------------------
interface mpc_result_if ();
  logic valid;
  logic ready;
  logic same_multiset;
  logic count_overflow;

  modport source (output valid, output same_multiset, output count_overflow,
                  input ready);
  modport sink (input valid, input same_multiset, input count_overflow,
                output ready);
endinterface

// ===== rtl/core/mpc_lane.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Count lane
// Occurrence counts of one sequence, kept modulo 2^CNT_W in a memory with two
// registered read ports and one write port. The write of the previous cycle is
// forwarded to the read data so that back-to-back pairs see current counts.
// ----------------------------------------------------------------------------
module mpc_lane #(
  parameter int VALUE_BITS = 10,
  parameter int CNT_W      = 17
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     rd_en_i,
  input  logic [VALUE_BITS-1:0]    rd_addr0_i,
  input  logic [VALUE_BITS-1:0]    rd_addr1_i,
  input  mpc_pkg::mpc_wr_ctrl_t    wr_ctrl_i,
  input  logic [VALUE_BITS-1:0]    clr_addr_i,
  output logic [CNT_W-1:0]         own_cnt_o,
  output logic [CNT_W-1:0]         other_cnt_o
);
  import mpc_pkg::*;

  localparam int Depth = 1 << VALUE_BITS;

  logic [CNT_W-1:0]      mem_q [Depth];
  logic [CNT_W-1:0]      rdata0_q, rdata1_q;
  logic [VALUE_BITS-1:0] addr0_q, addr1_q;
  logic                  lw_valid_q;
  logic [VALUE_BITS-1:0] lw_addr_q;
  logic [CNT_W-1:0]      lw_data_q;

  logic                  wr_en;
  logic [VALUE_BITS-1:0] wr_addr;
  logic [CNT_W-1:0]      wr_data;

  always_comb begin
    own_cnt_o   = (lw_valid_q && (lw_addr_q == addr0_q)) ? lw_data_q : rdata0_q;
    other_cnt_o = (lw_valid_q && (lw_addr_q == addr1_q)) ? lw_data_q : rdata1_q;
    wr_en       = wr_ctrl_i.clr_en | wr_ctrl_i.inc_en;
    wr_addr     = wr_ctrl_i.clr_en ? clr_addr_i : addr0_q;
    wr_data     = wr_ctrl_i.clr_en ? '0 : own_cnt_o + CNT_W'(1);
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rdata0_q <= mem_q[rd_addr0_i];
      rdata1_q <= mem_q[rd_addr1_i];
      addr0_q  <= rd_addr0_i;
      addr1_q  <= rd_addr1_i;
    end
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    lw_addr_q <= wr_addr;
    lw_data_q <= wr_data;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lw_valid_q <= 1'b0;
    end else begin
      lw_valid_q <= wr_en;
    end
  end

endmodule

// ===== rtl/core/mpc_merge.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Merge stage
// Combines the counts of both lanes into differences, keeps the number of
// nonzero differences, the set length and the overflow flag, and forms the
// verdict on the last pair of a set.
// ----------------------------------------------------------------------------
module mpc_merge #(
  parameter int VALUE_BITS = 10,
  parameter int MAX_LENGTH = 65535,
  parameter int CNT_W      = 17
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     s1_valid_i,
  input  logic                     s1_last_i,
  input  logic [VALUE_BITS-1:0]    s1_value_a_i,
  input  logic [VALUE_BITS-1:0]    s1_value_b_i,
  input  logic [CNT_W-1:0]         a_own_i,
  input  logic [CNT_W-1:0]         a_other_i,
  input  logic [CNT_W-1:0]         b_own_i,
  input  logic [CNT_W-1:0]         b_other_i,
  output logic                     inc_en_o,
  output mpc_pkg::mpc_merge_t      merge_o
);
  import mpc_pkg::*;

  localparam int PairW = $clog2(MAX_LENGTH + 1);
  localparam int NzW   = VALUE_BITS + 1;

  logic [NzW-1:0]   nz_q, nz_d;
  logic [PairW-1:0] pairs_q, pairs_d;
  logic             ovf_q, ovf_d;

  logic             ovf_now;
  logic             upd;
  logic [CNT_W-1:0] diff_a, diff_b;
  logic [1:0]       ups, downs;

  always_comb begin
    ovf_now  = (pairs_q == PairW'(MAX_LENGTH));
    upd      = s1_valid_i && !ovf_now && (s1_value_a_i != s1_value_b_i);
    diff_a   = a_own_i - b_other_i;
    diff_b   = a_other_i - b_own_i;
    ups      = 2'(diff_a == '0) + 2'(diff_b == '0);
    downs    = 2'(diff_a == '1) + 2'(diff_b == CNT_W'(1));
    nz_d     = upd ? (nz_q + NzW'(ups) - NzW'(downs)) : nz_q;
    ovf_d    = ovf_q | ovf_now;
    pairs_d  = ovf_now ? pairs_q : pairs_q + PairW'(1);
    inc_en_o = s1_valid_i && !ovf_now;

    merge_o.res_valid      = s1_valid_i && s1_last_i;
    merge_o.same_multiset  = (nz_d == '0) && !ovf_d;
    merge_o.count_overflow = ovf_d;
    merge_o.sweep_req      = (nz_d != '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nz_q    <= '0;
      pairs_q <= '0;
      ovf_q   <= 1'b0;
    end else if (s1_valid_i) begin
      if (s1_last_i) begin
        nz_q    <= '0;
        pairs_q <= '0;
        ovf_q   <= 1'b0;
      end else begin
        nz_q    <= nz_d;
        pairs_q <= pairs_d;
        ovf_q   <= ovf_d;
      end
    end
  end

endmodule

// ===== rtl/core/multiset_permutation_check.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Multiset permutation check
// Tells whether two streamed sequences hold the same values with the same
// multiplicities, using two count lanes and a merge stage.
// ----------------------------------------------------------------------------
// The block takes one pair per clock cycle when ready and answers each set
// through a two-entry result queue: the pair is registered into the merge
// stage, and its verdict is registered into the queue. The input stalls
// while that queue cannot take another verdict. Each lane keeps the
// occurrence counts of one sequence in a memory of 2^VALUE_BITS entries; the
// merge stage tracks how many values have unequal counts. A set that ends
// with all counts equal leaves the tables consistent and the next pair may
// follow at once. A set that ends with unequal counts starts a clearing pass
// over all 2^VALUE_BITS entries, one entry per cycle in both lanes; from the
// cycle in which its last pair is merged until the pass ends, no pair is
// accepted. The same pass runs once after reset. Sets longer than MAX_LENGTH
// pairs are reported with count_overflow set and same_multiset clear.
module multiset_permutation_check #(
  parameter int VALUE_BITS = 10,
  parameter int MAX_LENGTH = 65535
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  mpc_pair_if.sink      pair_i,
  mpc_result_if.source  result_o
);
  import mpc_pkg::*;

  localparam int PairW = $clog2(MAX_LENGTH + 1);
  localparam int CntW  = PairW + 1;

  logic                  accept;
  logic                  s1_valid_q;
  logic                  s1_last_q;
  logic [VALUE_BITS-1:0] s1_va_q, s1_vb_q;

  logic                  sweep_q;
  logic [VALUE_BITS-1:0] sweep_idx_q;

  logic [CntW-1:0]       a_own, a_other, b_own, b_other;
  logic                  inc_en;
  mpc_merge_t            merge;
  mpc_wr_ctrl_t          wr_ctrl;

  logic                  ent_same_q [2];
  logic                  ent_ovf_q [2];
  logic                  wr_ptr_q, rd_ptr_q;
  logic [1:0]            count_q, count_d;
  logic                  push, pop;

  always_comb begin
    push    = merge.res_valid;
    pop     = result_o.valid && result_o.ready;
    count_d = count_q + 2'(push) - 2'(pop);

    pair_i.ready = !sweep_q && !(merge.res_valid && merge.sweep_req) &&
                   (count_d <= 2'd1);
    accept       = pair_i.valid && pair_i.ready;

    wr_ctrl.inc_en = inc_en;
    wr_ctrl.clr_en = sweep_q;

    result_o.valid          = (count_q != 2'd0);
    result_o.same_multiset  = ent_same_q[rd_ptr_q];
    result_o.count_overflow = ent_ovf_q[rd_ptr_q];
  end

  mpc_lane #(
    .VALUE_BITS (VALUE_BITS),
    .CNT_W      (CntW)
  ) u_lane_a (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rd_en_i     (accept),
    .rd_addr0_i  (pair_i.value_a),
    .rd_addr1_i  (pair_i.value_b),
    .wr_ctrl_i   (wr_ctrl),
    .clr_addr_i  (sweep_idx_q),
    .own_cnt_o   (a_own),
    .other_cnt_o (a_other)
  );

  mpc_lane #(
    .VALUE_BITS (VALUE_BITS),
    .CNT_W      (CntW)
  ) u_lane_b (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rd_en_i     (accept),
    .rd_addr0_i  (pair_i.value_b),
    .rd_addr1_i  (pair_i.value_a),
    .wr_ctrl_i   (wr_ctrl),
    .clr_addr_i  (sweep_idx_q),
    .own_cnt_o   (b_own),
    .other_cnt_o (b_other)
  );

  mpc_merge #(
    .VALUE_BITS (VALUE_BITS),
    .MAX_LENGTH (MAX_LENGTH),
    .CNT_W      (CntW)
  ) u_merge (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s1_valid_i   (s1_valid_q),
    .s1_last_i    (s1_last_q),
    .s1_value_a_i (s1_va_q),
    .s1_value_b_i (s1_vb_q),
    .a_own_i      (a_own),
    .a_other_i    (a_other),
    .b_own_i      (b_own),
    .b_other_i    (b_other),
    .inc_en_o     (inc_en),
    .merge_o      (merge)
  );

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_last_q <= pair_i.last_pair;
      s1_va_q   <= pair_i.value_a;
      s1_vb_q   <= pair_i.value_b;
    end
    if (push) begin
      ent_same_q[wr_ptr_q] <= merge.same_multiset;
      ent_ovf_q[wr_ptr_q]  <= merge.count_overflow;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      sweep_q     <= 1'b1;
      sweep_idx_q <= '0;
      wr_ptr_q    <= 1'b0;
      rd_ptr_q    <= 1'b0;
      count_q     <= 2'd0;
    end else begin
      s1_valid_q <= accept;
      if (sweep_q) begin
        sweep_idx_q <= sweep_idx_q + VALUE_BITS'(1);
        if (sweep_idx_q == '1) begin
          sweep_q <= 1'b0;
        end
      end else if (merge.res_valid && merge.sweep_req) begin
        sweep_q     <= 1'b1;
        sweep_idx_q <= '0;
      end
      if (push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      count_q <= count_d;
    end
  end

endmodule

// ===== verif/mpc_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Multiset permutation check scoreboard
// Watches the pair and result channels and keeps its own difference
// histogram of the current set. It predicts the verdict for each set and
// compares each result transaction with the oldest pending verdict.
// ----------------------------------------------------------------------------
module mpc_checker #(
  parameter int VALUE_BITS = 10,
  parameter int MAX_LENGTH = 65535
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  pair_valid_i,
  input  logic                  pair_ready_i,
  input  logic [VALUE_BITS-1:0] value_a_i,
  input  logic [VALUE_BITS-1:0] value_b_i,
  input  logic                  last_pair_i,
  input  logic                  result_valid_i,
  input  logic                  result_ready_i,
  input  logic                  same_multiset_i,
  input  logic                  count_overflow_i,
  output int                    mismatch_count_o,
  output int                    verdicts_pending_o
);

  localparam int TableDepth = 1 << VALUE_BITS;

  typedef struct packed {
    logic same_multiset;
    logic count_overflow;
  } verdict_t;

  int       histogram [TableDepth];
  int       nonzero_values;
  int       set_length;
  logic     set_overflowed;
  verdict_t verdict_q [$];

  function automatic void adjust_count(input int idx, input int delta);
    int old_cnt;
    old_cnt = histogram[idx];
    histogram[idx] = old_cnt + delta;
    if (old_cnt == 0 && histogram[idx] != 0) begin
      nonzero_values++;
    end else if (old_cnt != 0 && histogram[idx] == 0) begin
      nonzero_values--;
    end
  endfunction

  function automatic void start_new_set();
    for (int i = 0; i < TableDepth; i++) begin
      histogram[i] = 0;
    end
    nonzero_values = 0;
    set_length = 0;
    set_overflowed = 1'b0;
  endfunction

  function automatic void take_pair(input logic [VALUE_BITS-1:0] a,
                                    input logic [VALUE_BITS-1:0] b,
                                    input logic last);
    verdict_t v;
    if (set_length >= MAX_LENGTH) begin
      set_overflowed = 1'b1;
    end else begin
      set_length++;
      if (a != b) begin
        adjust_count(int'(a), 1);
        adjust_count(int'(b), -1);
      end
    end
    if (last) begin
      v.same_multiset = (nonzero_values == 0) && !set_overflowed;
      v.count_overflow = set_overflowed;
      verdict_q.push_back(v);
      start_new_set();
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    verdict_t exp_v;
    if (!rst_ni) begin
      start_new_set();
      verdict_q.delete();
      mismatch_count_o = 0;
      verdicts_pending_o = 0;
    end else begin
      if (result_valid_i && result_ready_i) begin
        if (verdict_q.size() == 0) begin
          $display("%0t: unexpected result same_multiset=%0b count_overflow=%0b",
                   $time, same_multiset_i, count_overflow_i);
          mismatch_count_o++;
        end else begin
          exp_v = verdict_q.pop_front();
          if (exp_v.same_multiset !== same_multiset_i) begin
            $display("%0t: same_multiset expected %0b actual %0b",
                     $time, exp_v.same_multiset, same_multiset_i);
            mismatch_count_o++;
          end
          if (exp_v.count_overflow !== count_overflow_i) begin
            $display("%0t: count_overflow expected %0b actual %0b",
                     $time, exp_v.count_overflow, count_overflow_i);
            mismatch_count_o++;
          end
        end
      end
      if (pair_valid_i && pair_ready_i) begin
        take_pair(value_a_i, value_b_i, last_pair_i);
      end
      verdicts_pending_o = verdict_q.size();
    end
  end

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Multiset permutation check testbench
// Streams directed and random sets of pairs into the block, mostly true
// permutations with some corrupted ones, under several idle and stall
// patterns. A scoreboard module checks every verdict.
// ----------------------------------------------------------------------------
module testbench;

  localparam int VALUE_BITS = 10;
  localparam int MAX_LENGTH = 65535;
  localparam int MaxValue = (1 << VALUE_BITS) - 1;
  localparam int HoldCycles = 300;
  localparam int ItemsPerPhase = 350;

  logic clk_i;
  logic rst_ni;
  int   mismatch_count;
  int   verdicts_pending;
  int   items_sent;
  int   idle_pct;
  int   stall_pct;
  logic hold_go;
  logic hold_done;
  int   hold_cnt;

  logic [VALUE_BITS-1:0] seq_a [$];
  logic [VALUE_BITS-1:0] seq_b [$];

  mpc_pair_if #(.VALUE_BITS(VALUE_BITS)) pair_ch ();
  mpc_result_if result_ch ();

  multiset_permutation_check #(
    .VALUE_BITS(VALUE_BITS),
    .MAX_LENGTH(MAX_LENGTH)
  ) dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .pair_i  (pair_ch),
    .result_o(result_ch)
  );

  mpc_checker #(
    .VALUE_BITS(VALUE_BITS),
    .MAX_LENGTH(MAX_LENGTH)
  ) u_checker (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .pair_valid_i      (pair_ch.valid),
    .pair_ready_i      (pair_ch.ready),
    .value_a_i         (pair_ch.value_a),
    .value_b_i         (pair_ch.value_b),
    .last_pair_i       (pair_ch.last_pair),
    .result_valid_i    (result_ch.valid),
    .result_ready_i    (result_ch.ready),
    .same_multiset_i   (result_ch.same_multiset),
    .count_overflow_i  (result_ch.count_overflow),
    .mismatch_count_o  (mismatch_count),
    .verdicts_pending_o(verdicts_pending)
  );

  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  initial begin
    #50_000_000;
    $display("Mismatches found");
    $finish;
  end

  // Result side: random stalls, plus one long hold-off when requested.
  initial begin
    hold_done = 1'b0;
    hold_cnt = 0;
    result_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_go && !hold_done) begin
        hold_cnt++;
        if (hold_cnt >= HoldCycles) begin
          hold_done = 1'b1;
        end
        result_ch.ready <= 1'b0;
      end else begin
        result_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  task automatic send_pair(input logic [VALUE_BITS-1:0] a,
                           input logic [VALUE_BITS-1:0] b,
                           input logic last);
    while ($urandom_range(0, 99) < idle_pct) begin
      pair_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    pair_ch.valid <= 1'b1;
    pair_ch.value_a <= a;
    pair_ch.value_b <= b;
    pair_ch.last_pair <= last;
    @(posedge clk_i);
    while (!pair_ch.ready) begin
      @(posedge clk_i);
    end
    items_sent++;
  endtask

  task automatic drain_results();
    pair_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (verdicts_pending != 0) begin
      @(posedge clk_i);
    end
  endtask

  task automatic build_random_set();
    int len;
    int span;
    int kind;
    int k;
    logic [VALUE_BITS-1:0] tmp;
    len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
    span = ($urandom_range(0, 1) == 1) ? MaxValue : $urandom_range(1, 7);
    kind = $urandom_range(0, 99);
    seq_a.delete();
    seq_b.delete();
    for (int i = 0; i < len; i++) begin
      seq_a.push_back(VALUE_BITS'($urandom_range(0, span)));
      seq_b.push_back(seq_a[i]);
    end
    for (int j = len - 1; j > 0; j--) begin
      k = $urandom_range(0, j);
      tmp = seq_b[j];
      seq_b[j] = seq_b[k];
      seq_b[k] = tmp;
    end
    if (kind >= 70 && kind < 88) begin
      seq_b[$urandom_range(0, len - 1)] = VALUE_BITS'($urandom_range(0, span));
    end else if (kind >= 88) begin
      for (int i = 0; i < len; i++) begin
        seq_b[i] = VALUE_BITS'($urandom_range(0, MaxValue));
      end
    end
  endtask

  task automatic send_sequences();
    for (int i = 0; i < seq_a.size(); i++) begin
      send_pair(seq_a[i], seq_b[i], i == seq_a.size() - 1);
    end
  endtask

  initial begin
    logic [VALUE_BITS-1:0] va;
    int target;
    items_sent = 0;
    idle_pct = 0;
    stall_pct = 0;
    hold_go = 1'b0;
    rst_ni <= 1'b0;
    pair_ch.valid <= 1'b0;
    pair_ch.value_a <= '0;
    pair_ch.value_b <= '0;
    pair_ch.last_pair <= 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_pair(10'd7, 10'd7, 1'b1);
    send_pair(10'd0, 10'd1023, 1'b1);
    send_pair(10'd1023, 10'd1023, 1'b1);
    send_pair(10'd0, 10'd5, 1'b0);
    send_pair(10'd5, 10'd0, 1'b1);
    send_pair(10'd1023, 10'd0, 1'b0);
    send_pair(10'd0, 10'd1023, 1'b1);
    send_pair(10'd1, 10'd2, 1'b0);
    send_pair(10'd2, 10'd3, 1'b0);
    send_pair(10'd3, 10'd1, 1'b1);
    send_pair(10'h2AA, 10'h155, 1'b0);
    send_pair(10'h155, 10'h155, 1'b1);
    send_pair(10'h155, 10'h2AA, 1'b0);
    send_pair(10'h2AA, 10'h155, 1'b1);
    send_pair(10'd4, 10'd4, 1'b0);
    send_pair(10'd4, 10'd9, 1'b0);
    send_pair(10'd9, 10'd4, 1'b1);
    send_pair(10'd6, 10'd8, 1'b0);
    send_pair(10'd8, 10'd8, 1'b1);
    drain_results();

    // The result side holds off while single-pair sets keep coming.
    hold_go = 1'b1;
    for (int i = 0; i < 40; i++) begin
      va = VALUE_BITS'($urandom_range(0, MaxValue));
      send_pair(va, ($urandom_range(0, 3) == 0) ? ~va : va, 1'b1);
    end
    drain_results();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 59; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 59; end
        default: begin idle_pct = 38; stall_pct = 38; end
      endcase
      target = items_sent + ItemsPerPhase;
      while (items_sent < target) begin
        build_random_set();
        send_sequences();
      end
      drain_results();
    end

    repeat (20) @(posedge clk_i);
    if (mismatch_count == 0 && verdicts_pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
